FILE: sv/lre_pkg.sv
// ----------------------------------------------------------------------------
// lre_pkg: shared types for the eight-zone line rasterizer
// Coordinate widths, zone codes and the line state record used by the
// setup logic, the step logic and the top level.
// ----------------------------------------------------------------------------
package lre_pkg;

    // Width of one coordinate at the ports.
    localparam int COORD_BITS = 12;
    // Zone-0 coordinates need one more bit, since negating the most negative
    // port value must not wrap.
    localparam int MAJ_W      = COORD_BITS + 1;
    // Decision variable and diagonal increment.
    localparam int DEC_W      = COORD_BITS + 3;
    // East increment, never negative.
    localparam int EAST_W     = COORD_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [MAJ_W-1:0]      wide_coord_t;
    typedef logic signed [DEC_W-1:0]      dec_t;
    typedef logic        [EAST_W-1:0]     east_t;

    // Direction zones, counterclockwise from the shallow east-northeast zone.
    typedef enum logic [2:0] {
        ZONE_0 = 3'd0,
        ZONE_1 = 3'd1,
        ZONE_2 = 3'd2,
        ZONE_3 = 3'd3,
        ZONE_4 = 3'd4,
        ZONE_5 = 3'd5,
        ZONE_6 = 3'd6,
        ZONE_7 = 3'd7
    } zone_t;

    // Everything the block keeps about the line in progress.
    typedef struct packed {
        logic        active;
        zone_t       zone;
        wide_coord_t cur_major;
        wide_coord_t cur_minor;
        wide_coord_t end_major;
        dec_t        decision;
        east_t       east_step;
        dec_t        diag_step;
    } line_state_t;

    // One emitted pixel.
    typedef struct packed {
        coord_t x;
        coord_t y;
        zone_t  zone;
        logic   last;
    } point_t;

endpackage

FILE: sv/lre_setup.sv
// ----------------------------------------------------------------------------
// lre_setup: line setup for a load transfer
// Classifies the direction into a zone, folds both endpoints into zone 0 and
// derives the initial decision value and the two increments.
// ----------------------------------------------------------------------------
module lre_setup
(
    input  lre_pkg::coord_t      x_start,
    input  lre_pkg::coord_t      y_start,
    input  lre_pkg::coord_t      x_end,
    input  lre_pkg::coord_t      y_end,
    output lre_pkg::line_state_t setup
);

    // Maps an original-space point into zone 0.
    function automatic void to_zone0
    (
        input  lre_pkg::zone_t       z,
        input  lre_pkg::wide_coord_t x,
        input  lre_pkg::wide_coord_t y,
        output lre_pkg::wide_coord_t a,
        output lre_pkg::wide_coord_t b
    );
        unique case (z)
            lre_pkg::ZONE_0: begin a = x;  b = y;  end
            lre_pkg::ZONE_1: begin a = y;  b = x;  end
            lre_pkg::ZONE_2: begin a = y;  b = -x; end
            lre_pkg::ZONE_3: begin a = -x; b = y;  end
            lre_pkg::ZONE_4: begin a = -x; b = -y; end
            lre_pkg::ZONE_5: begin a = -y; b = -x; end
            lre_pkg::ZONE_6: begin a = -y; b = x;  end
            lre_pkg::ZONE_7: begin a = x;  b = -y; end
        endcase
    endfunction

    lre_pkg::wide_coord_t xs, ys, xe, ye;
    lre_pkg::wide_coord_t dx, dy;
    logic [lre_pkg::COORD_BITS-1:0] mag_dx, mag_dy;
    logic wide, dx_neg, dy_neg, dx_zero, dy_zero;
    lre_pkg::zone_t zone;
    lre_pkg::wide_coord_t a1, b1, a2, b2;
    lre_pkg::dec_t ddx, ddy;

    always_comb
    begin
        xs = lre_pkg::wide_coord_t'(x_start);
        ys = lre_pkg::wide_coord_t'(y_start);
        xe = lre_pkg::wide_coord_t'(x_end);
        ye = lre_pkg::wide_coord_t'(y_end);
        dx = xe - xs;
        dy = ye - ys;

        dx_neg  = dx[lre_pkg::MAJ_W-1];
        dy_neg  = dy[lre_pkg::MAJ_W-1];
        dx_zero = (dx == '0);
        dy_zero = (dy == '0);

        // The magnitude of a coordinate difference always fits COORD_BITS.
        mag_dx = dx_neg ? lre_pkg::COORD_BITS'(-dx) : lre_pkg::COORD_BITS'(dx);
        mag_dy = dy_neg ? lre_pkg::COORD_BITS'(-dy) : lre_pkg::COORD_BITS'(dy);
        wide   = (mag_dx > mag_dy);

        // Axis-aligned directions fall into the first matching quadrant.
        priority if (!dx_neg && !dy_neg)
            zone = wide ? lre_pkg::ZONE_0 : lre_pkg::ZONE_1;
        else if (!dx_neg && !dx_zero && dy_neg)
            zone = wide ? lre_pkg::ZONE_7 : lre_pkg::ZONE_6;
        else if ((dx_neg || dx_zero) && (dy_neg || dy_zero))
            zone = wide ? lre_pkg::ZONE_4 : lre_pkg::ZONE_5;
        else
            zone = wide ? lre_pkg::ZONE_3 : lre_pkg::ZONE_2;

        to_zone0(zone, xs, ys, a1, b1);
        to_zone0(zone, xe, ye, a2, b2);

        ddx = lre_pkg::dec_t'(a2) - lre_pkg::dec_t'(a1);
        ddy = lre_pkg::dec_t'(b2) - lre_pkg::dec_t'(b1);

        setup.active    = (a1 < a2);
        setup.zone      = zone;
        setup.cur_major = a1;
        setup.cur_minor = b1;
        setup.end_major = a2;
        setup.decision  = (ddy <<< 1) - ddx;
        setup.east_step = lre_pkg::EAST_W'(ddy <<< 1);
        setup.diag_step = (ddy - ddx) <<< 1;
    end

endmodule

FILE: sv/lre_stepper.sv
// ----------------------------------------------------------------------------
// lre_stepper: one midpoint step
// Advances the zone-0 position by one pixel, updates the decision value and
// maps the new pixel back into the line's original zone.
// ----------------------------------------------------------------------------
module lre_stepper
(
    input  lre_pkg::line_state_t cur,
    output lre_pkg::line_state_t nxt,
    output lre_pkg::point_t      point
);

    lre_pkg::wide_coord_t major_n, minor_n;
    lre_pkg::wide_coord_t px, py;
    logic fin;

    always_comb
    begin
        nxt     = cur;
        major_n = cur.cur_major + lre_pkg::wide_coord_t'(1);

        if (cur.decision[lre_pkg::DEC_W-1])
        begin
            minor_n      = cur.cur_minor;
            nxt.decision = cur.decision + lre_pkg::dec_t'({1'b0, cur.east_step});
        end
        else
        begin
            minor_n      = cur.cur_minor + lre_pkg::wide_coord_t'(1);
            nxt.decision = cur.decision + cur.diag_step;
        end

        fin           = (major_n >= cur.end_major);
        nxt.cur_major = major_n;
        nxt.cur_minor = minor_n;
        nxt.active    = cur.active && !fin;

        unique case (cur.zone)
            lre_pkg::ZONE_0: begin px = major_n;  py = minor_n;  end
            lre_pkg::ZONE_1: begin px = minor_n;  py = major_n;  end
            lre_pkg::ZONE_2: begin px = -minor_n; py = major_n;  end
            lre_pkg::ZONE_3: begin px = -major_n; py = minor_n;  end
            lre_pkg::ZONE_4: begin px = -major_n; py = -minor_n; end
            lre_pkg::ZONE_5: begin px = -minor_n; py = -major_n; end
            lre_pkg::ZONE_6: begin px = minor_n;  py = -major_n; end
            lre_pkg::ZONE_7: begin px = major_n;  py = -minor_n; end
        endcase

        point.x    = px[lre_pkg::COORD_BITS-1:0];
        point.y    = py[lre_pkg::COORD_BITS-1:0];
        point.zone = cur.zone;
        point.last = fin;
    end

endmodule

FILE: sv/line_rasterizer_eight_zone.sv
// ----------------------------------------------------------------------------
// line_rasterizer_eight_zone: eight-zone midpoint line generator
// Loads a line from two signed endpoints and emits one pixel per step
// transfer on an active line, mapped back to the line's original direction zone.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  input   | in_valid / in_stall   | action, x_start, y_start, x_end, y_end
//  output  | out_valid / out_stall | point_x, point_y, zone, last
//
// An input transfer is taken in every cycle in which in_stall is low; a step
// transfer's pixel is registered in the output register at the edge that takes
// the transfer. The step path is one decision add and one end compare feeding
// the line state register.
// rst_n clears the line state (no line active) and empties the output
// register. in_stall rises only while a pixel waits in the output register
// and out_stall holds it there.
//
// A load transfer (action = 0) gives no pixel and replaces any line in
// progress. A step transfer (action = 1) with no active line gives no pixel.
// The start point is never emitted; the end point carries last = 1, after
// which the line is inactive.
// ----------------------------------------------------------------------------
module line_rasterizer_eight_zone
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  lre_pkg::coord_t      x_start,
    input  lre_pkg::coord_t      y_start,
    input  lre_pkg::coord_t      x_end,
    input  lre_pkg::coord_t      y_end,

    output logic                 out_valid,
    input  logic                 out_stall,
    output lre_pkg::coord_t      point_x,
    output lre_pkg::coord_t      point_y,
    output lre_pkg::zone_t       zone,
    output logic                 last
);

    // Line state: the registered copy of everything the block keeps about
    // the current line.
    lre_pkg::line_state_t state_reg, state_next;
    lre_pkg::line_state_t setup_state, step_state;

    // Output register: one pixel and its valid flag.
    lre_pkg::point_t step_point;
    lre_pkg::point_t point_reg;
    logic            out_valid_reg, out_valid_next;

    logic in_accept;
    logic load_fire;
    logic step_fire;

    // Setup for a load transfer works straight off the input ports.
    lre_setup u_setup
    (
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .setup   (setup_state)
    );

    // The step path works off the stored line state.
    lre_stepper u_stepper
    (
        .cur   (state_reg),
        .nxt   (step_state),
        .point (step_point)
    );

    // The input side only waits when the output register holds a pixel that
    // the downstream side is not taking in this cycle.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign load_fire = in_accept && !action;
    assign step_fire = in_accept && action && state_reg.active;

    always_comb
    begin
        priority if (load_fire)
            state_next = setup_state;
        else if (step_fire)
            state_next = step_state;
        else
            state_next = state_reg;
    end

    // A new pixel always lands in the register; otherwise the old one stays
    // only while it is held back.
    assign out_valid_next = step_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The pixel payload is qualified by out_valid and needs no reset.
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            point_reg <= step_point;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_reg.x;
    assign point_y   = point_reg.y;
    assign zone      = point_reg.zone;
    assign last      = point_reg.last;

`ifndef NO_ASSERTIONS
    // Backpressure on the input comes only from a held pixel.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall raised without a held output pixel");

    // A fresh pixel only follows an accepted step transfer.
    a_pixel_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && action))
        else $error("pixel appeared without an accepted step transfer");

    // After the final pixel of a line no line remains active.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && step_point.last) |=> !state_reg.active)
        else $error("line still active after its final pixel");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the eight-zone midpoint line generator
// Drives load and step transfers through the input channel, predicts every
// pixel with a behavioral line tracer and checks each output transfer against
// the oldest predicted pixel, with random bursts on the input side and random
// stall patterns on the output side.
// ----------------------------------------------------------------------------
module tb;

    import lre_pkg::*;

    // Action codes carried in the action field.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Coordinate limits of the ports.
    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

    // Number of transfers in the random part.
    localparam int RANDOM_ITEMS = 600;

    // Output stall patterns; the receiver switches between them at random
    // so that stalls land on every phase of a line.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE,
        STALL_PERIODIC
    } stall_mode_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    logic    action    = ACT_LOAD;
    coord_t  x_start   = '0;
    coord_t  y_start   = '0;
    coord_t  x_end     = '0;
    coord_t  y_end     = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    coord_t  point_x;
    coord_t  point_y;
    zone_t   zone;
    logic    last;

    line_rasterizer_eight_zone uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .zone      (zone),
        .last      (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Line tracer. It keeps its own copy of the line state, at the same widths
    // as the block, and appends one pixel to pending_pixels for every step
    // transfer that lands on an active line.
    // ------------------------------------------------------------------------
    logic        trace_active = 1'b0;
    zone_t       trace_zone   = ZONE_0;
    wide_coord_t trace_major  = '0;
    wide_coord_t trace_minor  = '0;
    wide_coord_t trace_end    = '0;
    dec_t        trace_dec    = '0;
    east_t       trace_east   = '0;
    dec_t        trace_diag   = '0;

    point_t pending_pixels[$];

    int     err_count    = 0;
    int     load_count   = 0;
    int     step_count   = 0;
    int     sent_count   = 0;
    int     pixel_count  = 0;
    int     end_count    = 0;
    logic [7:0] zones_seen = '0;
    int     burst_left   = 0;
    bit     draining     = 1'b0;

    // Direction zone of a line, counterclockwise. Diagonals and the vertical
    // axis belong to the steep zones, the horizontal axis to the shallow ones.
    function automatic zone_t classify_dir(input int dx, input int dy);
        int adx;
        int ady;
        bit wide;
        adx  = (dx < 0) ? -dx : dx;
        ady  = (dy < 0) ? -dy : dy;
        wide = adx > ady;
        if (dx >= 0 && dy >= 0)
            return wide ? ZONE_0 : ZONE_1;
        if (dx > 0 && dy < 0)
            return wide ? ZONE_7 : ZONE_6;
        if (dx <= 0 && dy <= 0)
            return wide ? ZONE_4 : ZONE_5;
        return wide ? ZONE_3 : ZONE_2;
    endfunction

    // Mirror a point of zone z into zone 0 (major, minor).
    function automatic void fold_to_zone0(input zone_t z, input int x, input int y,
                                          output int a, output int b);
        case (z)
            ZONE_0:  begin a = x;  b = y;  end
            ZONE_1:  begin a = y;  b = x;  end
            ZONE_2:  begin a = y;  b = -x; end
            ZONE_3:  begin a = -x; b = y;  end
            ZONE_4:  begin a = -x; b = -y; end
            ZONE_5:  begin a = -y; b = -x; end
            ZONE_6:  begin a = -y; b = x;  end
            default: begin a = x;  b = -y; end
        endcase
    endfunction

    // Inverse of fold_to_zone0.
    function automatic void unfold_from_zone0(input zone_t z, input int a, input int b,
                                              output int x, output int y);
        case (z)
            ZONE_0:  begin x = a;  y = b;  end
            ZONE_1:  begin x = b;  y = a;  end
            ZONE_2:  begin x = -b; y = a;  end
            ZONE_3:  begin x = -a; y = b;  end
            ZONE_4:  begin x = -a; y = -b; end
            ZONE_5:  begin x = -b; y = -a; end
            ZONE_6:  begin x = b;  y = -a; end
            default: begin x = a;  y = -b; end
        endcase
    endfunction

    // A load replaces whatever line is in progress. A line whose endpoints
    // coincide never becomes active.
    function automatic void plot_setup(input int xs, input int ys, input int xe, input int ye);
        int a1, b1, a2, b2;
        int ddx, ddy;
        trace_zone = classify_dir(xe - xs, ye - ys);
        fold_to_zone0(trace_zone, xs, ys, a1, b1);
        fold_to_zone0(trace_zone, xe, ye, a2, b2);
        ddx = a2 - a1;
        ddy = b2 - b1;
        trace_major  = wide_coord_t'(a1);
        trace_minor  = wide_coord_t'(b1);
        trace_end    = wide_coord_t'(a2);
        trace_dec    = dec_t'(2 * ddy - ddx);
        trace_east   = east_t'(2 * ddy);
        trace_diag   = dec_t'(2 * (ddy - ddx));
        trace_active = a1 < a2;
    endfunction

    // One midpoint step; the east increment never exceeds the decision range.
    function automatic void plot_advance();
        point_t px;
        int     x, y;
        if (!trace_active)
            return;
        trace_major = trace_major + wide_coord_t'(1);
        if (trace_dec < 0)
            trace_dec = trace_dec + dec_t'({1'b0, trace_east});
        else
        begin
            trace_minor = trace_minor + wide_coord_t'(1);
            trace_dec   = trace_dec + trace_diag;
        end
        px.last = trace_major >= trace_end;
        if (px.last)
            trace_active = 1'b0;
        unfold_from_zone0(trace_zone, int'(trace_major), int'(trace_minor), x, y);
        px.x    = coord_t'(x);
        px.y    = coord_t'(y);
        px.zone = trace_zone;
        pending_pixels.push_back(px);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. The sender works in bursts: between bursts it mostly drops valid
    // for a random gap, now and then not at all, and some bursts are long. Valid
    // stays high from one transfer to the next inside a burst, so it gets only one
    // assignment per clock edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic act, input int xs, input int ys,
                             input int xe, input int ye);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(12, 1);
            gap        = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action   <= act;
        x_start  <= coord_t'(xs);
        y_start  <= coord_t'(ys);
        x_end    <= coord_t'(xe);
        y_end    <= coord_t'(ye);
        // The transfer happens at the first edge that sees in_stall low.
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (act == ACT_LOAD)
        begin
            plot_setup(xs, ys, xe, ye);
            load_count++;
        end
        else
        begin
            plot_advance();
            step_count++;
        end
        sent_count++;
    endtask

    function automatic int rnd_coord();
        return int'($urandom_range(COORD_MAX - COORD_MIN, 0)) + COORD_MIN;
    endfunction

    // A step carries coordinates the block ignores; they are random so that
    // every payload bit toggles on steps as well.
    task automatic send_step();
        send_item(ACT_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    // Start coordinate for an offset d that keeps both ends on the grid, now
    // and then pinned to one of the two limits.
    function automatic int pick_origin(input int d);
        int lo, hi, r;
        lo = (d < 0) ? COORD_MIN - d : COORD_MIN;
        hi = (d > 0) ? COORD_MAX - d : COORD_MAX;
        r  = $urandom_range(9, 0);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    // ------------------------------------------------------------------------
    // Output side: check every pixel transfer, then pick the next stall value.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_pixel();
        point_t want;
        if (pending_pixels.size() == 0)
        begin
            report_mismatch("pixel with none pending, point_x", int'(point_x), 0);
            return;
        end
        want = pending_pixels.pop_front();
        if (point_x !== want.x)
            report_mismatch("point_x", int'(point_x), int'(want.x));
        if (point_y !== want.y)
            report_mismatch("point_y", int'(point_y), int'(want.y));
        if (zone !== want.zone)
            report_mismatch("zone", int'(zone), int'(want.zone));
        if (last !== want.last)
            report_mismatch("last", int'(last), int'(want.last));
        pixel_count++;
        if (want.last)
            end_count++;
        zones_seen[want.zone] = 1'b1;
    endtask

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          phase      = 0;

    always @(posedge clk)
    begin
        logic hold;
        if (rst_n && out_valid && !out_stall)
            check_pixel();
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(4, 0));
            mode_left  = $urandom_range(96, 16);
        end
        mode_left--;
        phase++;
        case (stall_mode)
            STALL_NONE:      hold = 1'b0;
            STALL_LIGHT:     hold = ($urandom_range(7, 0) == 0);
            STALL_HEAVY:     hold = ($urandom_range(3, 0) != 0);
            STALL_ALTERNATE: hold = phase[0];
            default:         hold = (phase % 7) < 3;
        endcase
        // Once the stimulus is done the receiver drains without stalling.
        if (draining)
            hold = 1'b0;
        out_stall <= hold;
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // A step right after reset finds no line and must give no pixel.
    task automatic test_step_without_line();
        send_step();
    endtask

    // One short line per zone. The steep zones use exact diagonals, which sit
    // on the boundary between two zones; zones 0 and 4 use the horizontal
    // axis, and zones 3 and 7 need a major length of two.
    task automatic test_each_zone();
        int ends[8][4];
        int n;
        ends = '{'{10, 20, 11, 20},
                 '{-3, -3, -2, -2},
                 '{5, -7, 4, -6},
                 '{100, 100, 98, 101},
                 '{-50, 0, -51, 0},
                 '{7, 7, 6, 6},
                 '{0, 0, 1, -1},
                 '{-2000, 1000, -1998, 999}};
        for (int i = 0; i < 8; i++)
        begin
            send_item(ACT_LOAD, ends[i][0], ends[i][1], ends[i][2], ends[i][3]);
            n = (i == 3 || i == 7) ? 2 : 1;
            repeat (n) send_step();
        end
    endtask

    // Two corner-to-corner lines stress the widest decision and increment values,
    // each cut short by the next load. The last line is one step that ends on the grid limit.
    task automatic test_extreme_coords();
        send_item(ACT_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_step();
        send_item(ACT_LOAD, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_step();
        send_item(ACT_LOAD, COORD_MAX - 1, COORD_MIN, COORD_MAX, COORD_MIN);
        send_step();
    endtask

    // A zero-length line never activates, and a finished line stays finished.
    task automatic test_degenerate_lines();
        send_item(ACT_LOAD, 5, 5, 5, 5);
        send_step();
        send_item(ACT_LOAD, 0, 0, 1, 0);
        send_step();
        send_step();
    endtask

    // Mostly complete lines of random zone, length and slope, some walked a
    // few steps past their end and some abandoned for the next load; the rest
    // is unrestricted noise.
    task automatic test_random_lines();
        int stop_at, kind, len, minor, steps, r;
        int dx, dy, xs, ys;
        zone_t z;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 80)
            begin
                r = $urandom_range(99, 0);
                if (r < 80)
                    len = $urandom_range(12, 1);
                else if (r < 95)
                    len = $urandom_range(64, 13);
                else
                    len = $urandom_range(300, 65);
                r = $urandom_range(9, 0);
                minor = (r == 0) ? 0 : (r == 1) ? len : $urandom_range(len, 0);
                z = zone_t'($urandom_range(7, 0));
                unfold_from_zone0(z, len, minor, dx, dy);
                xs = pick_origin(dx);
                ys = pick_origin(dy);
                send_item(ACT_LOAD, xs, ys, xs + dx, ys + dy);
                r = $urandom_range(99, 0);
                steps = len;
                if (r < 15)
                    steps = len + $urandom_range(3, 1);
                else if (r < 30)
                    steps = $urandom_range(len - 1, 0);
                repeat (steps) send_step();
            end
            else if (kind < 90)
            begin
                send_item(ACT_LOAD, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
                repeat ($urandom_range(8, 0)) send_step();
            end
            else
            begin
                send_item(logic'($urandom_range(1, 0)),
                          rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_step_without_line();
        test_each_zone();
        test_extreme_coords();
        test_degenerate_lines();
        test_random_lines();

        in_valid <= 1'b0;
        draining  = 1'b1;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        // Give a stray pixel time to show up in the output register.
        repeat (8) @(posedge clk);

        $display("Sent %0d loads and %0d steps; checked %0d pixels, %0d of them line ends.",
                 load_count, step_count, pixel_count, end_count);
        $display("Zones reached by checked pixels (bit per zone): %08b", zones_seen);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d pixels still pending.", pending_pixels.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
sv/lre_pkg.sv
sv/lre_setup.sv
sv/lre_stepper.sv
sv/line_rasterizer_eight_zone.sv
dv/tb.sv
